### rtl/mwo_pkg.sv
// types, constants and a table function shared by the oscillator modules
package mwo_pkg;

   // shared multiplier operand and product widths
   localparam int MUL_A_W = 44;
   localparam int MUL_B_W = 21;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // harmonic sum accumulator and harmonic index
   localparam int ACC_W    = 36;
   localparam int HIDX_W   = 3;
   localparam int MAX_HARM = 1 << HIDX_W;

   // waveform selects
   localparam logic [2:0] CMD_SINE   = 3'd0;
   localparam logic [2:0] CMD_SQUARE = 3'd1;
   localparam logic [2:0] CMD_TRI    = 3'd2;
   localparam logic [2:0] CMD_HSAW   = 3'd3;
   localparam logic [2:0] CMD_SAW    = 3'd4;
   localparam logic [2:0] CMD_NOISE  = 3'd5;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

   localparam int INV_TWO_PI_Q20  = 166886;
   localparam int TWO_OVER_PI_Q30 = 683565276;
   localparam int CONST_SPLIT     = 20;
   localparam int RECIP_SHIFT     = 19;
   localparam int M_SHIFT         = 13;
   localparam int LFO_SCALE_BITS  = 44;
   localparam int HSAW_SHIFT      = 46;

   localparam logic signed [15:0] SQUARE_LEVEL = 16'sd1638;
   localparam logic signed [15:0] SAW_OFFSET   = 16'sd16384;
   localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;
   localparam logic [31:0] LFSR_SEED = 32'hFFFF_FFFF;

   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_FT_LO,
      MUL_FT_HI,
      MUL_LFO,
      MUL_DF,
      MUL_DS,
      MUL_K,
      MUL_Q,
      MUL_CLO,
      MUL_CHI
   } mul_op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_FT_LO,
      ST_FT_HI,
      ST_LFO,
      ST_DF,
      ST_LROM,
      ST_DS,
      ST_MRND,
      ST_K,
      ST_PHASE,
      ST_HROM,
      ST_SEL,
      ST_HACC,
      ST_CLO,
      ST_CHI,
      ST_WSUM,
      ST_HRND,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       load;
      mul_op_type mul_op;
      logic       ft_lo_en;
      logic       ft_hi_en;
      logic       lfo_en;
      logic       df_en;
      logic       rom_en;
      logic       rom_harm;
      logic       m_en;
      logic       phase_en;
      logic       harm_en;
      logic       wsum_en;
      logic       wsum_add;
      logic       wave_en;
      logic       hsaw_en;
      logic       out_en;
   } dp_cmd_type;

   typedef struct packed {
      logic is_hsaw;
      logic last_harm;
   } dp_stat_type;

   // q15 sine magnitude of a first-quadrant table position
   function automatic logic [15:0] sine_mag(input int unsigned pos, input int unsigned tbits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      int unsigned n;
      x  = (HALF_PI_Q30 * 64'(pos)) >> (tbits - 2);
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      for (n = 12; n >= 2; n = n - 2) begin
         t = Q30_ONE - ((x2 * t) >> 30) / 64'(n * (n + 1));
      end
      s = (x * t) >> 30;
      s = (s + (64'd1 << 14)) >> 15;
      return s[15:0];
   endfunction

endpackage

### rtl/mwo_ctrl.sv
// sequencer for the oscillator: steps the shared multiplier and sine table
module mwo_ctrl
   import mwo_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_FT_LO;
         ST_FT_LO: state_in = ST_FT_HI;
         ST_FT_HI: state_in = ST_LFO;
         ST_LFO:   state_in = ST_DF;
         ST_DF:    state_in = ST_LROM;
         ST_LROM:  state_in = ST_DS;
         ST_DS:    state_in = ST_MRND;
         ST_MRND:  state_in = ST_K;
         ST_K:     state_in = ST_PHASE;
         ST_PHASE: state_in = ST_HROM;
         ST_HROM:  state_in = ST_SEL;
         ST_SEL:   state_in = stat.is_hsaw ? ST_HACC : ST_OUT;
         ST_HACC:  state_in = stat.last_harm ? ST_CLO : ST_HROM;
         ST_CLO:   state_in = ST_CHI;
         ST_CHI:   state_in = ST_WSUM;
         ST_WSUM:  state_in = ST_HRND;
         ST_HRND:  state_in = ST_OUT;
         ST_OUT:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.mul_op = MUL_NONE;
      case (state_ff)
         ST_IDLE:  cmd.load = req_valid;
         ST_FT_LO: cmd.mul_op = MUL_FT_LO;
         ST_FT_HI: begin
            cmd.mul_op   = MUL_FT_HI;
            cmd.ft_lo_en = 1'b1;
         end
         ST_LFO: begin
            cmd.mul_op   = MUL_LFO;
            cmd.ft_hi_en = 1'b1;
         end
         ST_DF: begin
            cmd.mul_op = MUL_DF;
            cmd.lfo_en = 1'b1;
         end
         ST_LROM: begin
            cmd.df_en  = 1'b1;
            cmd.rom_en = 1'b1;
         end
         ST_DS:    cmd.mul_op = MUL_DS;
         ST_MRND:  cmd.m_en = 1'b1;
         ST_K:     cmd.mul_op = MUL_K;
         ST_PHASE: cmd.phase_en = 1'b1;
         ST_HROM: begin
            cmd.rom_en   = 1'b1;
            cmd.rom_harm = 1'b1;
         end
         ST_SEL: begin
            if (stat.is_hsaw) begin
               cmd.mul_op = MUL_Q;
            end else begin
               cmd.wave_en = 1'b1;
            end
         end
         ST_HACC:  cmd.harm_en = 1'b1;
         ST_CLO:   cmd.mul_op = MUL_CLO;
         ST_CHI: begin
            cmd.mul_op  = MUL_CHI;
            cmd.wsum_en = 1'b1;
         end
         ST_WSUM:  cmd.wsum_add = 1'b1;
         ST_HRND:  cmd.hsaw_en = 1'b1;
         ST_OUT:   cmd.out_en = out_free;
         default:  cmd.mul_op = MUL_NONE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.out_en) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/mwo_dpath.sv
// oscillator datapath: operand registers, shared multiplier, sine table, waveform shaping
module mwo_dpath
   import mwo_pkg::*;
#(
   parameter int SINE_TABLE_BITS = 10,
   parameter int HARMONICS       = 3,
   parameter int PHASE_BITS      = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   output dp_stat_type        stat,
   input  logic [2:0]         req_cmd,
   input  logic [23:0]        req_frequency,
   input  logic [31:0]        req_time_req,
   input  logic [15:0]        req_lfo_frequency,
   input  logic [15:0]        req_lfo_amplitude,
   output logic signed [15:0] rsp_sample
);

   localparam int S       = SINE_TABLE_BITS;
   localparam int P       = PHASE_BITS;
   localparam int QUARTER = 1 << (S - 2);
   localparam int ADDR_W  = S - 1;
   localparam logic [MUL_B_W-1:0] C_LO = MUL_B_W'(TWO_OVER_PI_Q30 % (1 << CONST_SPLIT));
   localparam logic [MUL_B_W-1:0] C_HI = MUL_B_W'(TWO_OVER_PI_Q30 / (1 << CONST_SPLIT));

   // captured word
   logic [2:0]  cmd_ff;
   logic [23:0] f_ff;
   logic [23:0] t_ff;
   logic [15:0] fl_ff;
   logic [15:0] depth_ff;

   // working registers
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic [23:0]               ft24_ff;
   logic [23:0]               lfo24_ff;
   logic [39:0]               df_ff;
   logic signed [MUL_A_W-1:0] m_ff, m_in;
   logic [P-1:0]              phase_ff, phase_in;
   logic [P-1:0]              hph_ff;
   logic [HIDX_W-1:0]         hidx_ff;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [PROD_W-1:0]  wsum_ff;
   logic [15:0]               mag_ff;
   logic                      sign_ff;
   logic [31:0]               lfsr_ff, lfsr_in;
   logic signed [15:0]        sample_ff, wave_in, hsaw_in;
   logic signed [15:0]        rsp_sample_ff;

   // constant tables
   logic [15:0]      rom_w   [QUARTER+1];
   logic [14:0]      frac_w  [MAX_HARM][MAX_HARM];
   logic [MUL_B_W-1:0] recip_w [MAX_HARM];

   for (genvar gi = 0; gi <= QUARTER; gi++) begin : g_rom
      localparam logic [15:0] MAG = sine_mag(gi, S);
      assign rom_w[gi] = MAG;
   end

   for (genvar gn = 0; gn < MAX_HARM; gn++) begin : g_div
      localparam logic [MUL_B_W-1:0] RECIP = MUL_B_W'(((1 << RECIP_SHIFT) + gn) / (gn + 1));
      assign recip_w[gn] = RECIP;
      for (genvar gr = 0; gr < MAX_HARM; gr++) begin : g_frac
         localparam logic [14:0] FRAC = 15'((gr * 32768) / (gn + 1));
         assign frac_w[gn][gr] = FRAC;
      end
   end

   // sine table lookup, quarter-wave folded
   logic [S-1:0]      rom_idx;
   logic [S-3:0]      rom_pos;
   logic [ADDR_W-1:0] rom_addr;

   always_comb begin
      rom_idx  = cmd.rom_harm ? hph_ff[P-1 -: S] : lfo24_ff[23 -: S];
      rom_pos  = rom_idx[S-3:0];
      rom_addr = rom_idx[S-2] ? (ADDR_W'(QUARTER) - ADDR_W'(rom_pos)) : ADDR_W'(rom_pos);
   end

   logic signed [16:0] sine_s;
   assign sine_s = sign_ff ? -$signed({1'b0, mag_ff}) : $signed({1'b0, mag_ff});

   // shared multiplier operand select
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_op)
         MUL_FT_LO: begin
            mul_a = MUL_A_W'(f_ff);
            mul_b = MUL_B_W'(t_ff[15:0]);
         end
         MUL_FT_HI: begin
            mul_a = MUL_A_W'(f_ff);
            mul_b = MUL_B_W'(t_ff[23:16]);
         end
         MUL_LFO: begin
            mul_a = MUL_A_W'(t_ff);
            mul_b = MUL_B_W'(fl_ff);
         end
         MUL_DF: begin
            mul_a = MUL_A_W'(f_ff);
            mul_b = MUL_B_W'(depth_ff);
         end
         MUL_DS: begin
            mul_a = MUL_A_W'(df_ff);
            mul_b = MUL_B_W'(sine_s);
         end
         MUL_K: begin
            mul_a = m_ff;
            mul_b = MUL_B_W'(INV_TWO_PI_Q20);
         end
         MUL_Q: begin
            mul_a = MUL_A_W'(mag_ff);
            mul_b = recip_w[hidx_ff];
         end
         MUL_CLO: begin
            mul_a = MUL_A_W'(acc_ff);
            mul_b = C_LO;
         end
         MUL_CHI: begin
            mul_a = MUL_A_W'(acc_ff);
            mul_b = C_HI;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   // modulation depth term, rounded half away from zero
   logic             pm_neg;
   logic [PROD_W-1:0] pm_mag;
   logic [PROD_W-1:0] pm_rnd;

   always_comb begin
      pm_neg = prod_ff[PROD_W-1];
      pm_mag = pm_neg ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
      pm_rnd = (pm_mag + (PROD_W'(1) << (M_SHIFT - 1))) >> M_SHIFT;
      m_in   = pm_neg ? -$signed(MUL_A_W'(pm_rnd)) : $signed(MUL_A_W'(pm_rnd));
   end

   // lfo phase offset brought to the phase width
   logic [P-1:0] lfo_part;
   logic [P-1:0] base;

   if (P < LFO_SCALE_BITS) begin : g_lfo_rnd
      localparam int RS = LFO_SCALE_BITS - P;
      logic [PROD_W-1:0] lt_rnd;
      logic [PROD_W-1:0] lt_val;
      always_comb begin
         lt_rnd = (pm_mag + (PROD_W'(1) << (RS - 1))) >> RS;
         lt_val = pm_neg ? -lt_rnd : lt_rnd;
      end
      assign lfo_part = lt_val[P-1:0];
   end else begin : g_lfo_shl
      logic [PROD_W-1:0] lt_shl;
      assign lt_shl   = PROD_W'(prod_ff) << (P - LFO_SCALE_BITS);
      assign lfo_part = lt_shl[P-1:0];
   end

   if (P >= 24) begin : g_base_wide
      assign base = P'(ft24_ff) << (P - 24);
   end else begin : g_base_narrow
      assign base = P'(ft24_ff >> (24 - P));
   end

   assign phase_in = lfo_part + base;

   // one harmonic term: sign(s) * trunc(|s| * 2^15 / n)
   logic [15:0]             hq;
   logic [HIDX_W:0]         hn;
   logic [HIDX_W+3:0]       hqn;
   logic [HIDX_W-1:0]       hr;
   logic [30:0]             term_mag;
   logic signed [ACC_W-1:0] term;

   always_comb begin
      hq       = prod_ff[RECIP_SHIFT +: 16];
      hn       = (HIDX_W+1)'(hidx_ff) + 1'b1;
      hqn      = hq[2:0] * hn;
      hr       = mag_ff[2:0] - hqn[2:0];
      term_mag = {hq, frac_w[hidx_ff][hr]};
      term     = sign_ff ? -$signed(ACC_W'(term_mag)) : $signed(ACC_W'(term_mag));
      acc_in   = acc_ff + term;
   end

   // harmonic saw final rounding
   logic              hs_neg;
   logic [PROD_W-1:0] hs_mag;
   logic [PROD_W-1:0] hs_rnd;

   always_comb begin
      hs_neg  = wsum_ff[PROD_W-1];
      hs_mag  = hs_neg ? PROD_W'(-wsum_ff) : PROD_W'(wsum_ff);
      hs_rnd  = (hs_mag + (PROD_W'(1) << (HSAW_SHIFT - 1))) >> HSAW_SHIFT;
      hsaw_in = hs_neg ? -$signed(hs_rnd[15:0]) : $signed(hs_rnd[15:0]);
   end

   // direct waveforms
   logic [15:0] tri_u;
   logic [15:0] sine_r;

   assign lfsr_in = lfsr_ff[0] ? ((lfsr_ff >> 1) ^ LFSR_TAPS) : (lfsr_ff >> 1);
   assign tri_u   = phase_ff[P-1 -: 16];
   assign sine_r  = 16'((17'(mag_ff) + 17'd2) >> 2);

   always_comb begin
      case (cmd_ff)
         CMD_SINE:   wave_in = sign_ff ? -$signed(sine_r) : $signed(sine_r);
         CMD_SQUARE: wave_in = ((phase_ff != '0) && !phase_ff[P-1]) ? SQUARE_LEVEL
                                                                    : -SQUARE_LEVEL;
         CMD_TRI: begin
            if ((tri_u < 16'd16384) || (tri_u >= 16'd49152)) begin
               wave_in = $signed(tri_u);
            end else begin
               wave_in = $signed(16'(17'd32768 - 17'(tri_u)));
            end
         end
         CMD_SAW:    wave_in = $signed({1'b0, ft24_ff[23:9]}) - SAW_OFFSET;
         CMD_NOISE:  wave_in = $signed({1'b0, lfsr_in[31:17]}) - SAW_OFFSET;
         default:    wave_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= LFSR_SEED;
      end else if (cmd.wave_en && (cmd_ff == CMD_NOISE)) begin
         lfsr_ff <= lfsr_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.load) begin
         cmd_ff   <= req_cmd;
         f_ff     <= req_frequency;
         t_ff     <= req_time_req[23:0];
         fl_ff    <= req_lfo_frequency;
         depth_ff <= req_lfo_amplitude;
      end
      if (cmd.ft_lo_en) ft24_ff <= prod_ff[23:0];
      if (cmd.ft_hi_en) ft24_ff <= ft24_ff + {prod_ff[7:0], 16'd0};
      if (cmd.lfo_en)   lfo24_ff <= prod_ff[23:0];
      if (cmd.df_en)    df_ff <= prod_ff[39:0];
      if (cmd.rom_en) begin
         mag_ff  <= rom_w[rom_addr];
         sign_ff <= rom_idx[S-1];
      end
      if (cmd.m_en) m_ff <= m_in;
      if (cmd.phase_en) begin
         phase_ff <= phase_in;
         hph_ff   <= phase_in;
         hidx_ff  <= '0;
         acc_ff   <= '0;
      end
      if (cmd.harm_en) begin
         acc_ff  <= acc_in;
         hph_ff  <= hph_ff + phase_ff;
         hidx_ff <= hidx_ff + 1'b1;
      end
      if (cmd.wsum_en)  wsum_ff <= prod_ff;
      if (cmd.wsum_add) wsum_ff <= wsum_ff + (prod_ff <<< CONST_SPLIT);
      if (cmd.wave_en)  sample_ff <= wave_in;
      if (cmd.hsaw_en)  sample_ff <= hsaw_in;
      if (cmd.out_en)   rsp_sample_ff <= sample_ff;
   end

   assign stat.is_hsaw   = (cmd_ff == CMD_HSAW);
   assign stat.last_harm = (hidx_ff == HIDX_W'(HARMONICS - 1));
   assign rsp_sample     = rsp_sample_ff;

endmodule

### rtl/multi_waveform_oscillator.sv
// multi-waveform oscillator with lfo phase modulation, top level
// one req word is worked on at a time: req_ready is high only while the sequencer is idle, so
// a new word is taken only after the last one is through; the work is paced by the
// single shared multiplier and the single read port of the sine table
// a finished sample waits in the rsp register while the next req word is taken
// reset: synchronous, active high; returns the sequencer to idle and seeds the noise lfsr to all ones
module multi_waveform_oscillator
   import mwo_pkg::*;
#(
   parameter int SINE_TABLE_BITS = 10,
   parameter int HARMONICS       = 3,
   parameter int PHASE_BITS      = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_cmd,
   input  logic [23:0]        req_frequency,
   input  logic [31:0]        req_time_req,
   input  logic [15:0]        req_lfo_frequency,
   input  logic [15:0]        req_lfo_amplitude,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_sample
);

   // command bundle from the sequencer, status back from the datapath
   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   // sequencer: at most one multiplier product or one table read per step
   mwo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   // datapath: phase f*t plus lfo offset, then the selected waveform
   mwo_dpath #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .HARMONICS       (HARMONICS),
      .PHASE_BITS      (PHASE_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (dp_cmd),
      .stat              (dp_stat),
      .req_cmd           (req_cmd),
      .req_frequency     (req_frequency),
      .req_time_req      (req_time_req),
      .req_lfo_frequency (req_lfo_frequency),
      .req_lfo_amplitude (req_lfo_amplitude),
      .rsp_sample        (rsp_sample)
   );

   // one word at a time: busy right after taking a word
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready still high after a word was taken");

   // a new sample is only presented while a word is in work
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("rsp_valid rose while the sequencer was idle");

   // leaving idle only happens on an accepted word
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(req_valid))
      else $error("sequencer left idle without a word");

endmodule

### tb/sv/tb_top.sv
// self-checking testbench for the multi-waveform oscillator
`timescale 1ns / 100ps

module tb_top
   import mwo_pkg::*;
();

   // selects beyond noise produce silence
   localparam logic [2:0] CMD_SILENT_LO = 3'd6;
   localparam logic [2:0] CMD_SILENT_HI = 3'd7;
   localparam int N_RANDOM = 1030;
   localparam int HOLD_CYCLES = 300;

   // sample predictor plus queue of pending samples
   class sample_scoreboard;
      logic [31:0] lfsr;
      logic signed [15:0] pending[$];
      int errors;

      function new();
         lfsr = LFSR_SEED;
         errors = 0;
      endfunction

      function longint round_half_away(longint v, int n);
         longint unsigned mag;
         longint unsigned half;
         if (n == 0) return v;
         half = 64'd1 << (n - 1);
         if (v >= 0) return longint'(($unsigned(v) + half) >> n);
         mag = 64'd0 - $unsigned(v);
         return -longint'((mag + half) >> n);
      endfunction

      // q15 table sine of a 10-bit table index
      function int table_sine(longint unsigned idx);
         longint unsigned quad, pos, x, x2, t, s;
         int n;
         idx = idx & 64'h3FF;
         quad = idx >> 8;
         pos = idx & 64'hFF;
         if (quad[0]) pos = 256 - pos;
         x = (64'd1686629713 * pos) >> 8;
         x2 = (x * x) >> 30;
         t = 64'd1 << 30;
         for (n = 12; n >= 2; n = n - 2)
            t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'(n * (n + 1));
         s = (x * t) >> 30;
         s = (s + 64'd16384) >> 15;
         return (quad >= 2) ? -int'(s) : int'(s);
      endfunction

      function int phase_sine(longint unsigned ph);
         return table_sine((ph & 64'hFFFF_FFFF) >> 22);
      endfunction

      function logic signed [15:0] predict(logic [2:0] cmd, logic [23:0] f, logic [31:0] t,
                                           logic [15:0] fl, logic [15:0] depth);
         longint unsigned ft, base, ph, lfo24, u;
         longint lfo_term, smp, acc;
         int ls;
         int n;
         ft = 64'(f) * 64'(t);
         base = (ft << 8) & 64'hFFFF_FFFF;
         lfo24 = (64'(fl) * 64'(t)) & 64'hFF_FFFF;
         ls = table_sine(lfo24 >> 14);
         lfo_term = round_half_away(longint'(64'(depth) * 64'(f)) * longint'(ls), 13);
         lfo_term = lfo_term * 166886;
         ph = $unsigned(round_half_away(lfo_term, 12));
         ph = (ph + base) & 64'hFFFF_FFFF;
         smp = 0;
         case (cmd)
            CMD_SINE: smp = round_half_away(phase_sine(ph), 2);
            CMD_SQUARE: smp = (ph != 0 && ph < 64'h8000_0000) ? 1638 : -1638;
            CMD_TRI: begin
               u = ph >> 16;
               if (u < 16384) smp = longint'(u);
               else if (u < 49152) smp = 32768 - longint'(u);
               else smp = longint'(u) - 65536;
            end
            CMD_HSAW: begin
               acc = 0;
               for (n = 1; n <= 3; n++)
                  acc += (longint'(phase_sine(ph * n)) * 32768) / n;
               smp = round_half_away(acc * 683565276, 46);
            end
            CMD_SAW: smp = longint'(base >> 17) - 16384;
            CMD_NOISE: begin
               if (lfsr[0]) lfsr = (lfsr >> 1) ^ LFSR_TAPS;
               else lfsr = lfsr >> 1;
               smp = longint'(lfsr >> 17) - 16384;
            end
            default: smp = 0;
         endcase
         return smp[15:0];
      endfunction

      function void note_word(logic [2:0] cmd, logic [23:0] f, logic [31:0] t,
                              logic [15:0] fl, logic [15:0] depth);
         pending.push_back(predict(cmd, f, t, fl, depth));
      endfunction

      function void check_sample(logic signed [15:0] actual);
         logic signed [15:0] want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected sample %0d", actual);
            return;
         end
         want = pending.pop_front();
         if (want !== actual) begin
            errors++;
            if (errors <= 10) $display("sample mismatch: expected %0d, got %0d", want, actual);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [2:0] req_cmd = '0;
   logic [23:0] req_frequency = '0;
   logic [31:0] req_time_req = '0;
   logic [15:0] req_lfo_frequency = '0;
   logic [15:0] req_lfo_amplitude = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [15:0] rsp_sample;

   sample_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_left = 0;

   multi_waveform_oscillator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_cmd(req_cmd), .req_frequency(req_frequency), .req_time_req(req_time_req),
      .req_lfo_frequency(req_lfo_frequency), .req_lfo_amplitude(req_lfo_amplitude),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_sample(rsp_sample)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      #5ms;
      $display("multi_waveform_oscillator test failed");
      $finish;
   end

   // receiver: check accepted samples, then pick next ready; long hold-off counted here
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_sample(rsp_sample);
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // offer one word, with random idle cycles first, and wait for acceptance
   task automatic send_word(logic [2:0] cmd, logic [23:0] f, logic [31:0] t,
                            logic [15:0] fl, logic [15:0] depth);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_frequency <= f;
      req_time_req <= t;
      req_lfo_frequency <= fl;
      req_lfo_amplitude <= depth;
      do @(posedge clock); while (!req_ready);
      sb.note_word(cmd, f, t, fl, depth);
   endtask

   // random field value biased toward the extremes now and then
   function automatic logic [31:0] pick(int bits);
      logic [31:0] v;
      int r;
      r = $urandom_range(15);
      v = $urandom();
      if (r == 0) v = '0;
      else if (r == 1) v = '1;
      else if (r < 5) v = v >> $urandom_range(31);
      return v & 32'((64'd1 << bits) - 1);
   endfunction

   initial begin
      int i;
      int waited;
      logic [2:0] c;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every select at zero and at full-scale fields
      for (i = 0; i < 8; i++) begin
         c = i[2:0];
         send_word(c, 24'd0, 32'd0, 16'd0, 16'd0);
         send_word(c, 24'hFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF);
      end
      send_word(CMD_SINE, 24'd112640, 32'd1234, 16'd0, 16'd0);
      send_word(CMD_HSAW, 24'd56320, 32'd77777, 16'd1280, 16'd8192);
      send_word(CMD_SQUARE, 24'd1, 32'd1, 16'd1, 16'hFFFF);
      send_word(CMD_TRI, 24'h800000, 32'h80000000, 16'h8000, 16'h8000);
      send_word(CMD_SAW, 24'd256, 32'd65535, 16'd0, 16'd0);
      send_word(CMD_SILENT_LO, 24'h123456, 32'hDEADBEEF, 16'h1234, 16'h4321);
      send_word(CMD_SILENT_HI, 24'd7, 32'd9, 16'd11, 16'd13);
      send_word(CMD_NOISE, 24'd0, 32'd0, 16'd0, 16'd0);

      // random phases of idling; receiver holds off at the start of the first
      for (i = 0; i < N_RANDOM; i++) begin
         case ((i * 4) / N_RANDOM)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 57; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 57; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
         endcase
         if (i == 20) hold_left = HOLD_CYCLES;
         send_word(3'($urandom_range(7)), 24'(pick(24)), pick(32), 16'(pick(16)),
                   16'(pick(16)));
      end
      req_valid <= 1'b0;
      recv_stall_pct = 0;

      waited = 0;
      while (sb.pending.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      if (sb.pending.size() != 0) begin
         $display("multi_waveform_oscillator test failed");
         $finish;
      end else begin
         repeat (40) @(posedge clock);
         if (sb.errors == 0 && sb.pending.size() == 0)
            $display("multi_waveform_oscillator test passed");
         else
            $display("multi_waveform_oscillator test failed");
         $finish;
      end
   end

endmodule
